// ===== src/imu_collision_detector_core_defines.svh =====
// Assertion macros for the IMU collision detector.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef IMU_COLLISION_DETECTOR_CORE_DEFINES_SVH
`define IMU_COLLISION_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ICD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ICD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/icd_pkg.sv =====
// Constants and types for the IMU collision detector.
// No dependencies.
package icd_pkg;

  localparam int ACC_W    = 16;
  localparam int MEAN_W   = 17;
  localparam int DIFF_W   = 18;
  localparam int PROD_W   = 32;
  localparam int FLOOR_W  = 24;
  localparam int GYRO_W   = 13;
  localparam int LCNT_W   = 12;
  localparam int THR_W    = 27;
  localparam int VOUT_W   = 34;
  localparam int LV_W     = 24;
  localparam int LSUM_W   = 36;
  localparam int LSQ_W    = 60;
  localparam int LPROD_W  = 48;
  localparam int DNUM_W   = 60;
  localparam int DEN_W    = 12;
  localparam int CNT_W    = 6;
  localparam int RAD_W    = 48;
  localparam int ROOT_W   = 24;
  localparam int REM_W    = ROOT_W + 3;
  localparam int GROOT_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(2800);
  localparam logic [GYRO_W-1:0]  GYRO_RESET  = GYRO_W'(45);
  localparam logic [LCNT_W-1:0]  LEARN_RESET = LCNT_W'(3000);
  localparam logic [LV_W-1:0]    LEARN_SAT   = {LV_W{1'b1}};
  localparam logic [1:0]         CONFIRM_LOAD = 2'd3;
  localparam logic [DEN_W-1:0]   GYRO_DIV    = DEN_W'(10);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FLOOR = 2'd0;
  localparam cfg_idx_t REG_GYRO  = 2'd1;
  localparam cfg_idx_t REG_LEARN = 2'd2;

endpackage

// ===== src/imu_collision_detector_core.sv =====
// Top level of the IMU collision detector: window, variance, gyro magnitude,
// threshold learning and alarm. Depends on icd_pkg and the defines header.
`include "imu_collision_detector_core_defines.svh"

// One sample is taken at a time. A sample occupies the block from the cycle
// in which it is taken in until its result is loaded into the output register,
// and longer while the threshold is still being learned. The shared bit-serial
// divider (one quotient bit per cycle) and the shared square-root unit (one
// root bit per cycle) set the length of that work; the window pass adds one
// multiply per axis and sample. A finished result waits in the output
// register while the next sample is taken in.
module imu_collision_detector_core
  import icd_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ACC_W-1:0]   in_acc_x,
  input  logic signed [ACC_W-1:0]   in_acc_y,
  input  logic signed [ACC_W-1:0]   in_acc_z,
  input  logic signed [ACC_W-1:0]   in_rate_x,
  input  logic signed [ACC_W-1:0]   in_rate_y,
  input  logic signed [ACC_W-1:0]   in_rate_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_collision_alarm,
  output logic [VOUT_W-1:0]         out_accel_variance,
  output logic [GYRO_W-1:0]         out_gyro_magnitude,
  output logic [THR_W-1:0]          out_active_threshold,
  output logic                      out_learning,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  cfg_idx_t                  cfg_index,
  input  logic [FLOOR_W-1:0]        cfg_data
);

  localparam int SUM_W = 17 + $clog2(WINDOW);
  localparam int SQ_W  = 34 + $clog2(WINDOW);
  localparam int IDX_W = $clog2(WINDOW);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_MEAN_LD = 5'd1;
  localparam logic [4:0] ST_DIV     = 5'd2;
  localparam logic [4:0] ST_MEAN_WB = 5'd3;
  localparam logic [4:0] ST_PASS    = 5'd4;
  localparam logic [4:0] ST_PASS_FL = 5'd5;
  localparam logic [4:0] ST_VAR_LD  = 5'd6;
  localparam logic [4:0] ST_VAR_WB  = 5'd7;
  localparam logic [4:0] ST_GSQ     = 5'd8;
  localparam logic [4:0] ST_GSQ_FL  = 5'd9;
  localparam logic [4:0] ST_GRT_LD  = 5'd10;
  localparam logic [4:0] ST_SQRT    = 5'd11;
  localparam logic [4:0] ST_GDIV_LD = 5'd12;
  localparam logic [4:0] ST_GYRO_WB = 5'd13;
  localparam logic [4:0] ST_LRN0    = 5'd14;
  localparam logic [4:0] ST_LRN1    = 5'd15;
  localparam logic [4:0] ST_LRN_M   = 5'd16;
  localparam logic [4:0] ST_LRN_MM1 = 5'd17;
  localparam logic [4:0] ST_LRN_MM2 = 5'd18;
  localparam logic [4:0] ST_LRN_DIF = 5'd19;
  localparam logic [4:0] ST_LRN_V   = 5'd20;
  localparam logic [4:0] ST_LRN_THR = 5'd21;
  localparam logic [4:0] ST_DECIDE  = 5'd22;

  // configuration
  logic [FLOOR_W-1:0] floor_r;
  logic [GYRO_W-1:0]  gyro_thr_r;
  logic [LCNT_W-1:0]  learn_samples_r;

  // control
  logic [4:0]       state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0]       ax_r, ax_nxt;
  logic [IDX_W-1:0] samp_r, samp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // window and sums
  logic signed [ACC_W-1:0]  win_r [WINDOW][3];
  logic signed [SUM_W-1:0]  sum_r [3];
  logic signed [MEAN_W-1:0] mean_r [3];
  logic signed [ACC_W-1:0]  acc_in [3];
  logic signed [ACC_W-1:0]  rate_r [3];

  // squaring pipeline
  logic signed [DIFF_W-1:0]   d_val, mul_a;
  logic signed [2*DIFF_W-1:0] mul_p;
  logic [PROD_W-1:0]          prod_r;
  logic                       prod_v_r;
  logic [SQ_W-1:0]            acc_r;
  logic [SQ_W-1:0]            var_r;
  logic [GYRO_W-1:0]          gyro_r;

  // divider
  logic [DNUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt, rem_r, rem_nxt;
  logic [DEN_W:0]    rem_sh, rem_dif;
  logic              div_ge;
  logic [SUM_W-1:0]  mean_mag;

  // square root
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  srem_r, srem_nxt, srem_sh, sq_trial;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic              sq_ge;

  // learning
  logic [LCNT_W-1:0]  learn_count_r;
  logic [LSUM_W-1:0]  learn_sum_r;
  logic [LSQ_W-1:0]   learn_sq_r;
  logic [LV_W-1:0]    learn_v, m_r, mmhi_r, lm_a, lm_b;
  logic [LPROD_W-1:0] lm_p, lprod_r;
  logic [LSQ_W-1:0]   mmn_r, lrn_diff;
  logic [THR_W-1:0]   thr_r, thr_raw, thr_sel;
  logic               learning_r;

  // alarm
  logic [1:0] confirm_r, cc_load, cc_dec;
  logic       armed, out_load;

  logic out_valid_r, alarm_r, out_lrn_r;
  logic [VOUT_W-1:0] out_var_r;
  logic [GYRO_W-1:0] out_gyro_r;
  logic [THR_W-1:0]  out_thr_r;

  logic in_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign acc_in[0] = in_acc_x;
  assign acc_in[1] = in_acc_y;
  assign acc_in[2] = in_acc_z;

  assign out_valid            = out_valid_r;
  assign out_collision_alarm  = alarm_r;
  assign out_accel_variance   = out_var_r;
  assign out_gyro_magnitude   = out_gyro_r;
  assign out_active_threshold = out_thr_r;
  assign out_learning         = out_lrn_r;

  // ---------------- datapath helpers ----------------
  assign d_val = DIFF_W'(win_r[WINDOW-1][ax_r]) - DIFF_W'(mean_r[ax_r]);
  assign mul_a = (state_r == ST_PASS) ? d_val : DIFF_W'(rate_r[ax_r]);
  assign mul_p = mul_a * mul_a;

  assign mean_mag = sum_r[ax_r][SUM_W-1] ? SUM_W'(-sum_r[ax_r]) : SUM_W'(sum_r[ax_r]);

  assign rem_sh  = {rem_r, num_r[DNUM_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, den_r});
  assign rem_dif = rem_sh - {1'b0, den_r};

  assign srem_sh  = {srem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (srem_sh >= sq_trial);

  assign learn_v = (var_r > SQ_W'(LEARN_SAT)) ? LEARN_SAT : var_r[LV_W-1:0];

  always_comb begin
    unique case (state_r)
      ST_LRN0: begin
        lm_a = learn_v;
        lm_b = learn_v;
      end
      ST_LRN_M: begin
        lm_a = num_r[LV_W-1:0];
        lm_b = num_r[LV_W-1:0];
      end
      ST_LRN_MM1: begin
        lm_a = lprod_r[LV_W-1:0];
        lm_b = LV_W'(learn_count_r);
      end
      ST_LRN_MM2: begin
        lm_a = mmhi_r;
        lm_b = LV_W'(learn_count_r);
      end
      default: begin
        lm_a = '0;
        lm_b = '0;
      end
    endcase
  end
  assign lm_p = lm_a * lm_b;

  assign lrn_diff = (learn_sq_r >= mmn_r) ? (learn_sq_r - mmn_r) : '0;
  assign thr_raw  = THR_W'(m_r) + (THR_W'(root_r) << 2) + (THR_W'(root_r) << 1);
  assign thr_sel  = (thr_raw < THR_W'(floor_r)) ? THR_W'(floor_r) : thr_raw;

  assign armed    = (var_r > SQ_W'(thr_r)) && (gyro_r > gyro_thr_r);
  assign cc_load  = armed ? CONFIRM_LOAD : confirm_r;
  assign cc_dec   = (cc_load != 2'd0) ? (cc_load - 2'd1) : 2'd0;
  assign out_load = (state_r == ST_DECIDE) && (!out_valid_r || !out_stall);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    ax_nxt    = ax_r;
    samp_nxt  = samp_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    rad_nxt   = rad_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ax_nxt    = 2'd0;
          state_nxt = ST_MEAN_LD;
        end
      end
      ST_MEAN_LD: begin
        num_nxt   = DNUM_W'(mean_mag) << (DNUM_W - SUM_W);
        den_nxt   = DEN_W'(WINDOW);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(SUM_W);
        ret_nxt   = ST_MEAN_WB;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        num_nxt = {num_r[DNUM_W-2:0], div_ge};
        rem_nxt = div_ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ret_r;
        end
      end
      ST_MEAN_WB: begin
        if (ax_r == 2'd2) begin
          ax_nxt    = 2'd0;
          samp_nxt  = '0;
          state_nxt = ST_PASS;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ST_MEAN_LD;
        end
      end
      ST_PASS: begin
        if (ax_r == 2'd2) begin
          ax_nxt   = 2'd0;
          samp_nxt = samp_r + IDX_W'(1);
          if (samp_r == IDX_W'(WINDOW - 1)) begin
            state_nxt = ST_PASS_FL;
          end
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
      ST_PASS_FL: state_nxt = ST_VAR_LD;
      ST_VAR_LD: begin
        num_nxt   = DNUM_W'(acc_r) << (DNUM_W - SQ_W);
        den_nxt   = DEN_W'(WINDOW);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(SQ_W);
        ret_nxt   = ST_VAR_WB;
        state_nxt = ST_DIV;
      end
      ST_VAR_WB: begin
        ax_nxt    = 2'd0;
        state_nxt = ST_GSQ;
      end
      ST_GSQ: begin
        if (ax_r == 2'd2) begin
          ax_nxt    = 2'd0;
          state_nxt = ST_GSQ_FL;
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
      ST_GSQ_FL: state_nxt = ST_GRT_LD;
      ST_GRT_LD: begin
        rad_nxt   = {acc_r[2*GROOT_W-1:0], {(RAD_W - 2*GROOT_W){1'b0}}};
        srem_nxt  = '0;
        root_nxt  = '0;
        cnt_nxt   = CNT_W'(GROOT_W);
        ret_nxt   = ST_GDIV_LD;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        rad_nxt  = rad_r << 2;
        srem_nxt = sq_ge ? (srem_sh - sq_trial) : srem_sh;
        root_nxt = {root_r[ROOT_W-2:0], sq_ge};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ret_r;
        end
      end
      ST_GDIV_LD: begin
        num_nxt   = DNUM_W'(root_r[GROOT_W-1:0]) << (DNUM_W - GROOT_W);
        den_nxt   = GYRO_DIV;
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(GROOT_W);
        ret_nxt   = ST_GYRO_WB;
        state_nxt = ST_DIV;
      end
      ST_GYRO_WB: begin
        state_nxt = (learn_count_r < learn_samples_r) ? ST_LRN0 : ST_DECIDE;
      end
      ST_LRN0: state_nxt = ST_LRN1;
      ST_LRN1: begin
        num_nxt   = DNUM_W'(learn_sum_r) << (DNUM_W - LSUM_W);
        den_nxt   = DEN_W'(learn_count_r);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(LSUM_W);
        ret_nxt   = ST_LRN_M;
        state_nxt = ST_DIV;
      end
      ST_LRN_M:   state_nxt = ST_LRN_MM1;
      ST_LRN_MM1: state_nxt = ST_LRN_MM2;
      ST_LRN_MM2: state_nxt = ST_LRN_DIF;
      ST_LRN_DIF: begin
        // a negative spread divides to zero
        num_nxt   = DNUM_W'(lrn_diff);
        den_nxt   = DEN_W'(learn_count_r);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(LSQ_W);
        ret_nxt   = ST_LRN_V;
        state_nxt = ST_DIV;
      end
      ST_LRN_V: begin
        rad_nxt   = num_r[RAD_W-1:0];
        srem_nxt  = '0;
        root_nxt  = '0;
        cnt_nxt   = CNT_W'(ROOT_W);
        ret_nxt   = ST_LRN_THR;
        state_nxt = ST_SQRT;
      end
      ST_LRN_THR: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      ax_r    <= 2'd0;
      samp_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      ax_r    <= ax_nxt;
      samp_r  <= samp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    rad_r  <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r         <= FLOOR_RESET;
      gyro_thr_r      <= GYRO_RESET;
      learn_samples_r <= LEARN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FLOOR: floor_r         <= cfg_data;
        REG_GYRO:  gyro_thr_r      <= cfg_data[GYRO_W-1:0];
        REG_LEARN: learn_samples_r <= cfg_data[LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // window: shift in on a new sample, rotate by one sample after each sample's three pass steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[i][k] <= '0;
        end
      end
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= '0;
      end
    end else if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        win_r[0][k] <= acc_in[k];
        sum_r[k]    <= sum_r[k] + SUM_W'(acc_in[k]) - SUM_W'(win_r[WINDOW-1][k]);
      end
      for (int i = 1; i < WINDOW; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end else if (state_r == ST_PASS && ax_r == 2'd2) begin
      win_r[0] <= win_r[WINDOW-1];
      for (int i = 1; i < WINDOW; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate_r[0] <= in_rate_x;
      rate_r[1] <= in_rate_y;
      rate_r[2] <= in_rate_z;
    end
    if (state_r == ST_MEAN_WB) begin
      mean_r[ax_r] <= sum_r[ax_r][SUM_W-1] ? -MEAN_W'(num_r[MEAN_W-1:0])
                                           :  MEAN_W'(num_r[MEAN_W-1:0]);
    end
    prod_r <= mul_p[PROD_W-1:0];
    if (in_acc || state_r == ST_VAR_LD) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + SQ_W'(prod_r);
    end
    if (state_r == ST_VAR_WB) begin
      var_r <= num_r[SQ_W-1:0];
    end
    if (state_r == ST_GYRO_WB) begin
      gyro_r <= num_r[GYRO_W-1:0];
    end
    if (state_r == ST_LRN0 || state_r == ST_LRN_M) begin
      lprod_r <= lm_p;
    end
    if (state_r == ST_LRN_M) begin
      m_r <= num_r[LV_W-1:0];
    end
    if (state_r == ST_LRN_MM1) begin
      mmhi_r <= lprod_r[LPROD_W-1:LV_W];
      mmn_r  <= LSQ_W'(lm_p);
    end else if (state_r == ST_LRN_MM2) begin
      mmn_r <= mmn_r + (LSQ_W'(lm_p) << LV_W);
    end
    if (out_load) begin
      alarm_r    <= (cc_dec == 2'd1);
      out_var_r  <= var_r[VOUT_W-1:0];
      out_gyro_r <= gyro_r;
      out_thr_r  <= thr_r;
      out_lrn_r  <= learning_r;
    end
  end

  // learning statistics, threshold, confirm counter, output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r      <= 1'b0;
      learn_count_r <= '0;
      learn_sum_r   <= '0;
      learn_sq_r    <= '0;
      thr_r         <= THR_W'(FLOOR_RESET);
      learning_r    <= 1'b0;
      confirm_r     <= 2'd0;
      out_valid_r   <= 1'b0;
    end else begin
      prod_v_r <= (state_r == ST_PASS) || (state_r == ST_GSQ);
      if (state_r == ST_GYRO_WB) begin
        learning_r <= (learn_count_r < learn_samples_r);
      end
      if (state_r == ST_LRN0) begin
        learn_sum_r   <= learn_sum_r + LSUM_W'(learn_v);
        learn_count_r <= learn_count_r + LCNT_W'(1);
      end
      if (state_r == ST_LRN1) begin
        learn_sq_r <= learn_sq_r + LSQ_W'(lprod_r);
      end
      if (state_r == ST_LRN_THR) begin
        thr_r <= thr_sel;
      end
      if (out_load) begin
        confirm_r   <= cc_dec;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `ICD_ASSERT_NOW(a_alarm_count, out_valid_r && alarm_r, confirm_r == 2'd1,
                  "alarm shown without a pending confirm count")
  `ICD_ASSERT_NEXT(a_thr_floor, state_r == ST_LRN_THR, thr_r >= THR_W'(floor_r),
                   "learned threshold below floor")
  `ICD_ASSERT_NOW(a_lrn_count, out_valid_r && out_lrn_r, learn_count_r != '0,
                  "learning flag set with no learned sample")
  `ICD_ASSERT_NOW(a_unit_count, state_r == ST_DIV || state_r == ST_SQRT, cnt_r != '0,
                  "serial unit running with empty step count")

endmodule
